// ----- sv/sddf_pkg.sv -----
package sddf_pkg;

  localparam int MAX_DIGITS  = 8;
  localparam int IN_W        = 32;
  localparam int BCD_DIGITS  = 10;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int RED_W       = 4 * MAX_DIGITS;
  localparam int POS_W       = 3;
  localparam int CODE_W      = 4;
  localparam int CNT_W       = 4;
  localparam int DEC_W       = 3;
  localparam int BIT_CNT_W   = 5;
  localparam int OUT_DATA_W  = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = 1;
  localparam int FIFO_CNT_W  = 2;

  localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
  localparam logic [CODE_W-1:0] CODE_BLANK = 4'd11;

  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMAL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_ZERO     = 2'd2;

  localparam logic [CNT_W-1:0]     RESET_DIGITS   = 4'd4;
  localparam logic [CNT_W-1:0]     MAX_DIGITS_VAL = 4'd8;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT       = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PLAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              neg;
    logic [IN_W-1:0]   mag;
    logic [CNT_W-1:0]  digits;
    logic [DEC_W-1:0]  decimals;
    logic              show_zero;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    state_t state;
    logic   busy;
  } back_status_t;

endpackage

// ----- sv/signed_decimal_digit_formatter_unit.sv -----
// Each value is read from the queue, converted by a 32-step shift-add-3 loop,
// laid out in one plan step and then emitted as one code word per cycle while
// out_tready does not stall the output; the back end reads its next value from
// the queue only after the last code word of the current one has been loaded.
// A two-entry queue lets the front take up to two values while the back works.
// Reset (rst_n low, synchronous): queue and output emptied, digit_count 4,
// decimal_count 0, show_zero 0.
module signed_decimal_digit_formatter_unit
  import sddf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [31:0] value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] position, [6:3] digit_code, [7] zero
  output logic                  out_tlast
);

  entry_t       push_entry;
  entry_t       head_entry;
  fifo_status_t fifo_status;
  back_status_t back_status;
  logic         push;
  logic         pop;

  sddf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .fifo_status (fifo_status),
    .push        (push),
    .entry       (push_entry)
  );

  sddf_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_entry),
    .pop     (pop),
    .rd_data (head_entry),
    .status  (fifo_status)
  );

  sddf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry       (head_entry),
    .fifo_status (fifo_status),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .status      (back_status)
  );

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:3] <= CODE_BLANK))
    else $error("digit code out of range");

  a_plan_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (back_status.state == ST_PLAN) |-> ($past(back_status.state) == ST_CONV))
    else $error("plan step not preceded by conversion");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!back_status.busy && !fifo_status.empty))
    else $error("queue read while back end busy or queue empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !back_status.busy))
    else $error("output or back end active after reset");

endmodule

// ----- sv/sddf_fifo.sv -----
module sddf_fifo
  import sddf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  entry_t       wr_data,
  input  logic         pop,
  output entry_t       rd_data,
  output fifo_status_t status
);

  entry_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign status.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- sv/sddf_front.sv -----
module sddf_front
  import sddf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  input  fifo_status_t          fifo_status,
  output logic                  push,
  output entry_t                entry
);

  logic [CNT_W-1:0] digit_count_r, digit_count_nxt;
  logic [DEC_W-1:0] decimal_count_r, decimal_count_nxt;
  logic             show_zero_r, show_zero_nxt;
  logic [CNT_W-1:0] digits;
  logic [CNT_W-1:0] max_dec;
  logic             cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_tready = !fifo_status.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    digit_count_nxt   = digit_count_r;
    decimal_count_nxt = decimal_count_r;
    show_zero_nxt     = show_zero_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DIGIT_COUNT:   digit_count_nxt   = cfg_data[CNT_W-1:0];
        REG_DECIMAL_COUNT: decimal_count_nxt = cfg_data[DEC_W-1:0];
        REG_SHOW_ZERO:     show_zero_nxt     = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r   <= RESET_DIGITS;
      decimal_count_r <= '0;
      show_zero_r     <= 1'b0;
    end else begin
      digit_count_r   <= digit_count_nxt;
      decimal_count_r <= decimal_count_nxt;
      show_zero_r     <= show_zero_nxt;
    end
  end

  // clamp the digit count to 1..MAX_DIGITS and decimals below it
  always_comb begin
    if (digit_count_r == '0) begin
      digits = CNT_W'(1);
    end else if (digit_count_r > MAX_DIGITS_VAL) begin
      digits = MAX_DIGITS_VAL;
    end else begin
      digits = digit_count_r;
    end
    max_dec = digits - 1'b1;
    entry.digits    = digits;
    entry.decimals  = ({1'b0, decimal_count_r} > max_dec) ? max_dec[DEC_W-1:0]
                                                          : decimal_count_r;
    entry.show_zero = show_zero_r;
    entry.neg       = in_tdata[IN_W-1];
    entry.mag       = in_tdata[IN_W-1] ? (~in_tdata + 1'b1) : in_tdata;
  end

endmodule

// ----- sv/sddf_back.sv -----
module sddf_back
  import sddf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  entry_t                entry,
  input  fifo_status_t          fifo_status,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output back_status_t          status
);

  state_t                state_r, state_nxt;
  logic [IN_W-1:0]       mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic [CNT_W-1:0]      digits_r, digits_nxt;
  logic [DEC_W-1:0]      dec_r, dec_nxt;
  logic                  showz_r, showz_nxt;
  logic [RED_W-1:0]      red_r, red_nxt;
  logic [CNT_W-1:0]      shown_r, shown_nxt;
  logic                  dash_r, dash_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]      out_pos_r, out_pos_nxt;
  logic [CODE_W-1:0]     out_code_r, out_code_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  load;
  logic                  at_last;
  logic [CNT_W-1:0]      last_pos;
  logic [CNT_W-1:0]      keep;
  logic [CNT_W-1:0]      nd;
  logic [CNT_W-1:0]      dec1;
  logic [BCD_W-1:0]      bcd_adj;
  logic [RED_W-1:0]      red_c;
  logic [POS_W-1:0]      idx;
  logic [CODE_W-1:0]     code;

  assign load     = !out_valid_r || out_tready;
  assign last_pos = digits_r - 1'b1;
  assign at_last  = ({1'b0, pos_r} == last_pos);

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {1'b0, out_code_r, out_pos_r};
  assign out_tlast    = out_last_r;
  assign status.state = state_r;
  assign status.busy  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!fifo_status.empty) state_nxt = ST_CONV;
      ST_CONV: if (bit_cnt_r == LAST_BIT) state_nxt = ST_PLAN;
      ST_PLAN: state_nxt = ST_EMIT;
      ST_EMIT: if (load && at_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // shift-add-3 step, layout plan and code selection
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                   : bcd_r[4*i +: 4];
    end
    keep = digits_r - CNT_W'(neg_r);
    nd   = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      red_c[4*i +: 4] = (CNT_W'(i) < keep) ? bcd_r[4*i +: 4] : 4'd0;
      if (red_c[4*i +: 4] != 4'd0) begin
        nd = CNT_W'(i + 1);
      end
    end
    dec1 = {1'b0, dec_r} + 1'b1;
    idx  = last_pos[POS_W-1:0] - pos_r;
    if (dash_r) begin
      code = CODE_MINUS;
    end else if ({1'b0, idx} < shown_r) begin
      code = red_r[{idx, 2'b00} +: 4];
    end else if (neg_r && ({1'b0, idx} == shown_r)) begin
      code = CODE_MINUS;
    end else begin
      code = CODE_BLANK;
    end
  end

  always_comb begin
    pop           = 1'b0;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    neg_nxt       = neg_r;
    digits_nxt    = digits_r;
    dec_nxt       = dec_r;
    showz_nxt     = showz_r;
    red_nxt       = red_r;
    shown_nxt     = shown_r;
    dash_nxt      = dash_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_status.empty) begin
          pop         = 1'b1;
          mag_nxt     = entry.mag;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          neg_nxt     = entry.neg;
          digits_nxt  = entry.digits;
          dec_nxt     = entry.decimals;
          showz_nxt   = entry.show_zero;
        end
      end
      ST_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[IN_W-1]};
        mag_nxt     = {mag_r[IN_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
      end
      ST_PLAN: begin
        red_nxt   = red_c;
        shown_nxt = (nd > dec1) ? nd : dec1;
        dash_nxt  = (nd == '0) && !showz_r;
        pos_nxt   = '0;
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_code_nxt  = code;
          out_last_nxt  = at_last;
          pos_nxt       = pos_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    neg_r      <= neg_nxt;
    digits_r   <= digits_nxt;
    dec_r      <= dec_nxt;
    showz_r    <= showz_nxt;
    red_r      <= red_nxt;
    shown_r    <= shown_nxt;
    dash_r     <= dash_nxt;
    pos_r      <= pos_nxt;
    out_pos_r  <= out_pos_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ----- tb/sv/tb_signed_decimal_digit_formatter_unit.sv -----
module tb_signed_decimal_digit_formatter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sddf_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int RECV_HOLD   = 300;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CODE_W-1:0] code;
    logic              last;
  } code_word_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  logic [CNT_W-1:0] digits_reg   = RESET_DIGITS;
  logic [DEC_W-1:0] decimals_reg = '0;
  logic             zero_reg     = 1'b0;

  logic [IN_W-1:0] value_q [$];
  code_word_t      code_q  [$];
  code_word_t      got_word;

  int          errors      = 0;
  int          idle_cycles = 0;
  int unsigned send_gap    = 0;
  int unsigned recv_wait   = 0;
  bit          calm        = 1'b0;
  bit          hold_req    = 1'b0;

  signed_decimal_digit_formatter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_digits(input logic [CNT_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_DIGITS) return MAX_DIGITS;
    return n;
  endfunction

  function automatic longint unsigned pow10(input int unsigned k);
    longint unsigned p;
    p = 1;
    repeat (k) p *= 10;
    return p;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Expand one value into the code words of every position in use.
  function automatic void predict_display(input logic [IN_W-1:0] word);
    logic [CODE_W-1:0] codes [MAX_DIGITS];
    logic              neg;
    longint unsigned   mag, m;
    int unsigned       d, dec, nd, shown;
    code_word_t        w;
    neg = word[IN_W-1];
    mag = word;
    if (neg) mag = (64'd1 << IN_W) - mag;
    d   = eff_digits(digits_reg);
    dec = (decimals_reg > d - 1) ? d - 1 : decimals_reg;
    mag = mag % pow10(neg ? d - 1 : d);
    if (mag == 0 && !zero_reg) begin
      for (int unsigned k = 0; k < d; k++) codes[k] = CODE_MINUS;
    end else begin
      nd = 0;
      for (m = mag; m != 0; m /= 10) nd++;
      shown = (nd > dec + 1) ? nd : dec + 1;
      if (shown > d) shown = d;
      for (int unsigned k = 0; k < d; k++) codes[k] = CODE_BLANK;
      m = mag;
      for (int unsigned k = 0; k < shown; k++) begin
        codes[d-1-k] = CODE_W'(m % 10);
        m /= 10;
      end
      if (neg && shown < d) codes[d-1-shown] = CODE_MINUS;
    end
    for (int unsigned k = 0; k < d; k++) begin
      w.pos  = POS_W'(k);
      w.code = codes[k];
      w.last = (k == d - 1);
      code_q.push_back(w);
    end
  endfunction

  function automatic logic [IN_W-1:0] random_value();
    int unsigned     d, r;
    logic [IN_W-1:0] v;
    d = eff_digits(digits_reg);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      v = $urandom_range(0, 32'(pow10(d) - 1));
    end else if (r < 60) begin
      v = $urandom();
    end else if (r < 72) begin
      v = IN_W'($urandom_range(1, 9) * pow10($urandom_range(0, 9)));
    end else if (r < 82) begin
      v = IN_W'(pow10($urandom_range(d - 1, d)) * $urandom_range(0, 3));
    end else begin
      case ($urandom_range(0, 5))
        0:       v = 32'h7fff_ffff;
        1:       v = 32'h8000_0000;
        2:       v = '0;
        3:       v = IN_W'(pow10(d) - 1);
        4:       v = IN_W'(pow10(d - 1) - 1);
        default: v = 32'd1;
      endcase
    end
    if (r < 82 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DIGIT_COUNT:   digits_reg   = val;
      REG_DECIMAL_COUNT: decimals_reg = val[DEC_W-1:0];
      REG_SHOW_ZERO:     zero_reg     = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (value_q.size() != 0 || in_tvalid || code_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_DATA_W-1:0] nd, input logic [CFG_DATA_W-1:0] ndec,
                             input logic nz);
    wait_drained();
    write_reg(REG_DIGIT_COUNT, nd);
    write_reg(REG_DECIMAL_COUNT, ndec);
    write_reg(REG_SHOW_ZERO, CFG_DATA_W'(nz));
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_display(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (value_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= value_q.pop_front();
          send_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      recv_wait = RECV_HOLD;
      out_tready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      recv_wait = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (code_q.size() == 0) begin
        flag_mismatch("unexpected word", 8'h00, out_tdata);
      end else begin
        got_word = code_q.pop_front();
        if (out_tdata[POS_W-1:0] !== got_word.pos)
          flag_mismatch("position", 8'(got_word.pos), 8'(out_tdata[POS_W-1:0]));
        if (out_tdata[POS_W+CODE_W-1:POS_W] !== got_word.code)
          flag_mismatch("digit_code", 8'(got_word.code),
                        8'(out_tdata[POS_W+CODE_W-1:POS_W]));
        if (out_tdata[OUT_DATA_W-1] !== 1'b0)
          flag_mismatch("pad bit", 8'h00, 8'(out_tdata[OUT_DATA_W-1]));
        if (out_tlast !== got_word.last)
          flag_mismatch("last", 8'(got_word.last), 8'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    value_q = '{32'd0, 32'd1, -32'sd1, 32'd9999, 32'd10000, -32'sd999, -32'sd1000,
                32'h7fff_ffff, 32'h8000_0000};
    reconfigure(4'd8, 4'd7, 1'b1);
    value_q = '{32'd0, -32'sd10000000, -32'sd5, 32'd1234567, 32'h8000_0000};
    reconfigure(4'd0, 4'd3, 1'b1);
    value_q = '{32'd0, -32'sd1, 32'd7, -32'sd3};
    reconfigure(4'd15, 4'd0, 1'b0);
    value_q = '{-32'sd10, 32'd0, 32'd99999999};
    reconfigure(4'd9, 4'd2, 1'b1);
    value_q = '{32'd0, -32'sd5, -32'sd25};

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        reconfigure(4'd8, 4'd0, 1'b0);
      end else if (p == 1) begin
        reconfigure(4'd1, 4'd0, 1'b1);
      end else begin
        reconfigure(CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(1, 8)),
                    CFG_DATA_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end
      calm = (p == 2);
      if (p == 4) hold_req = 1'b1;
      repeat (55) value_q.push_back(random_value());
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/sddf_pkg.sv
sv/sddf_fifo.sv
sv/sddf_front.sv
sv/sddf_back.sv
sv/signed_decimal_digit_formatter_unit.sv
tb/sv/tb_signed_decimal_digit_formatter_unit.sv
